[src/lswc_pkg.sv]
// Shared types and constants for the line segment window clipper.
// Holds outcode bits, register indexes and the edge cut descriptor.
// No dependencies.
package lswc_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_XMIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_XMAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_YMIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_YMAX = 4'd3;

  // Outcode bits and the region codes that the clipper handles.
  localparam logic [3:0] OC_INSIDE     = 4'd0;
  localparam logic [3:0] OC_LEFT       = 4'd1;
  localparam logic [3:0] OC_RIGHT      = 4'd2;
  localparam logic [3:0] OC_BELOW      = 4'd4;
  localparam logic [3:0] OC_ABOVE      = 4'd8;
  localparam logic [3:0] OC_LEFT_BELOW = 4'd5;
  localparam logic [3:0] OC_LEFT_ABOVE = 4'd9;

  typedef enum logic {
    MOVE_A = 1'b0,
    MOVE_B = 1'b1
  } move_t;

  typedef enum logic [1:0] {
    EDGE_XMIN = 2'd0,
    EDGE_XMAX = 2'd1,
    EDGE_YMIN = 2'd2,
    EDGE_YMAX = 2'd3
  } edge_t;

  typedef struct packed {
    logic  en;
    move_t mv;
    edge_t edge_sel;
  } cut_desc_t;

endpackage

[src/line_segment_window_clipper_unit.sv]
// Top level of the line segment window clipper: window registers, front end
// and two chained edge-cut pipelines. Depends on lswc_pkg, lswc_front, lswc_cut.
//
//   channel   ports                                   handshake
//   input     in_first_x/y, in_second_x/y             start high, busy low
//   result    out_visible, out_clip_left/right_x/y    out_valid for one cycle
//   config    cfg_index, cfg_data                     cfg_we high
//
// One segment is taken every cycle. The pipeline holds five front-end stages,
// then two cut pipelines that each resolve one quotient bit per stage of
// their restoring divider.
// Reset clears the valid bits and loads the default window; busy stays low.
// The result side cannot stall, so the pipeline never holds.
module line_segment_window_clipper_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_BITS-1:0]     in_first_x,
  input  logic signed [COORD_BITS-1:0]     in_first_y,
  input  logic signed [COORD_BITS-1:0]     in_second_x,
  input  logic signed [COORD_BITS-1:0]     in_second_y,
  output logic                             out_valid,
  output logic                             out_visible,
  output logic signed [COORD_BITS-1:0]     out_clip_left_x,
  output logic signed [COORD_BITS-1:0]     out_clip_left_y,
  output logic signed [COORD_BITS-1:0]     out_clip_right_x,
  output logic signed [COORD_BITS-1:0]     out_clip_right_y,
  input  logic                             cfg_we,
  input  logic [lswc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data
);

  localparam int W      = COORD_BITS;
  localparam int DESC_W = $bits(lswc_pkg::cut_desc_t);
  localparam logic [W-1:0] WIN_HI_RST = W'(32'sd32767);

  logic signed [W-1:0] win_xmin_r, win_xmax_r, win_ymin_r, win_ymax_r;

  logic                f_valid, f_vis;
  logic signed [W-1:0] f_ax, f_ay, f_bx, f_by;
  lswc_pkg::cut_desc_t f_k1, f_k2;

  logic                k1_valid;
  logic signed [W-1:0] k1_ax, k1_ay, k1_bx, k1_by;
  logic [DESC_W:0]     k1_side;

  logic                k2_valid;
  logic [0:0]          k2_side;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_xmin_r <= '0;
      win_xmax_r <= WIN_HI_RST;
      win_ymin_r <= '0;
      win_ymax_r <= WIN_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lswc_pkg::REG_WIN_XMIN: win_xmin_r <= cfg_data;
        lswc_pkg::REG_WIN_XMAX: win_xmax_r <= cfg_data;
        lswc_pkg::REG_WIN_YMIN: win_ymin_r <= cfg_data;
        lswc_pkg::REG_WIN_YMAX: win_ymax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lswc_front #(.W(W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .i_valid    (start && !busy),
    .i_first_x  (in_first_x),
    .i_first_y  (in_first_y),
    .i_second_x (in_second_x),
    .i_second_y (in_second_y),
    .win_xmin   (win_xmin_r),
    .win_xmax   (win_xmax_r),
    .win_ymin   (win_ymin_r),
    .win_ymax   (win_ymax_r),
    .o_valid    (f_valid),
    .o_vis      (f_vis),
    .o_ax       (f_ax),
    .o_ay       (f_ay),
    .o_bx       (f_bx),
    .o_by       (f_by),
    .o_k1       (f_k1),
    .o_k2       (f_k2)
  );

  // The second cut's descriptor rides along the first cut as side data.
  lswc_cut #(.W(W), .SIDE_W(DESC_W + 1)) u_cut1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (f_valid),
    .i_ax     (f_ax),
    .i_ay     (f_ay),
    .i_bx     (f_bx),
    .i_by     (f_by),
    .i_desc   (f_k1),
    .i_side   ({f_vis, f_k2}),
    .win_xmin (win_xmin_r),
    .win_xmax (win_xmax_r),
    .win_ymin (win_ymin_r),
    .win_ymax (win_ymax_r),
    .o_valid  (k1_valid),
    .o_ax     (k1_ax),
    .o_ay     (k1_ay),
    .o_bx     (k1_bx),
    .o_by     (k1_by),
    .o_side   (k1_side)
  );

  lswc_cut #(.W(W), .SIDE_W(1)) u_cut2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (k1_valid),
    .i_ax     (k1_ax),
    .i_ay     (k1_ay),
    .i_bx     (k1_bx),
    .i_by     (k1_by),
    .i_desc   (lswc_pkg::cut_desc_t'(k1_side[DESC_W-1:0])),
    .i_side   (k1_side[DESC_W]),
    .win_xmin (win_xmin_r),
    .win_xmax (win_xmax_r),
    .win_ymin (win_ymin_r),
    .win_ymax (win_ymax_r),
    .o_valid  (k2_valid),
    .o_ax     (out_clip_left_x),
    .o_ay     (out_clip_left_y),
    .o_bx     (out_clip_right_x),
    .o_by     (out_clip_right_y),
    .o_side   (k2_side)
  );

  assign out_valid   = k2_valid;
  assign out_visible = k2_side[0];

endmodule

[src/lswc_front.sv]
// Front end of the clipper: endpoint ordering, outcodes, slope products,
// slope compares and the region decision. Five register stages.
// Depends on lswc_pkg.
module lswc_front #(
  parameter int W = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      i_valid,
  input  logic signed [W-1:0]       i_first_x,
  input  logic signed [W-1:0]       i_first_y,
  input  logic signed [W-1:0]       i_second_x,
  input  logic signed [W-1:0]       i_second_y,
  input  logic signed [W-1:0]       win_xmin,
  input  logic signed [W-1:0]       win_xmax,
  input  logic signed [W-1:0]       win_ymin,
  input  logic signed [W-1:0]       win_ymax,
  output logic                      o_valid,
  output logic                      o_vis,
  output logic signed [W-1:0]       o_ax,
  output logic signed [W-1:0]       o_ay,
  output logic signed [W-1:0]       o_bx,
  output logic signed [W-1:0]       o_by,
  output lswc_pkg::cut_desc_t       o_k1,
  output lswc_pkg::cut_desc_t       o_k2
);

  localparam int PW = 2 * W + 2;

  // Stage 0: ordered endpoints.
  logic                v0_r;
  logic signed [W-1:0] ax0_r, ay0_r, bx0_r, by0_r;

  // Stage 1: outcodes and differences.
  logic                v1_r;
  logic signed [W-1:0] ax1_r, ay1_r, bx1_r, by1_r;
  logic [3:0]          c1_1_r, c2_1_r;
  logic signed [W:0]   dx1_r, dy1_r, dxl1_r, dxr1_r, dyb1_r, dyt1_r;
  logic                empty1_r, bxgt1_r;

  // Stage 2: slope products.
  logic                v2_r;
  logic signed [W-1:0] ax2_r, ay2_r, bx2_r, by2_r;
  logic [3:0]          c1_2_r, c2_2_r;
  logic                empty2_r, bxgt2_r, dypos2_r, dyneg2_r;
  logic signed [PW-1:0] p_dydxr_r, p_dydxl_r, p_dxdyt_r, p_dxdyb_r;
  logic signed [PW-1:0] p_dybdxr_r, p_dxldyt_r, p_dytdxr_r, p_dxldyb_r;

  // Stage 3: slope compare flags.
  logic                v3_r;
  logic signed [W-1:0] ax3_r, ay3_r, bx3_r, by3_r;
  logic [3:0]          c1_3_r, c2_3_r;
  logic                empty3_r, bxgt3_r, dypos3_r, dyneg3_r;
  logic                lt_rt_r, gt_rt_r, lt_rb_r, gt_rb_r;
  logic                gt_lt_r, lt_lb_r, lt_c_r, gt_c_r;

  // Stage 4 next values.
  logic                vis_nxt;
  lswc_pkg::cut_desc_t k1_nxt, k2_nxt;

  logic                swap;
  logic [3:0]          c1_nxt, c2_nxt;

  function automatic lswc_pkg::cut_desc_t mk(lswc_pkg::move_t m, lswc_pkg::edge_t e);
    lswc_pkg::cut_desc_t d;
    d.en       = 1'b1;
    d.mv       = m;
    d.edge_sel = e;
    return d;
  endfunction

  function automatic logic [3:0] outcode(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                         logic signed [W-1:0] x0, logic signed [W-1:0] x1,
                                         logic signed [W-1:0] y0, logic signed [W-1:0] y1);
    logic [3:0] c;
    c = lswc_pkg::OC_INSIDE;
    if (x < x0) c = c | lswc_pkg::OC_LEFT;
    if (x > x1) c = c | lswc_pkg::OC_RIGHT;
    if (y < y0) c = c | lswc_pkg::OC_BELOW;
    if (y > y1) c = c | lswc_pkg::OC_ABOVE;
    return c;
  endfunction

  assign swap   = i_first_x > i_second_x;
  assign c1_nxt = outcode(ax0_r, ay0_r, win_xmin, win_xmax, win_ymin, win_ymax);
  assign c2_nxt = outcode(bx0_r, by0_r, win_xmin, win_xmax, win_ymin, win_ymax);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      v0_r    <= i_valid;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      o_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 0
    ax0_r <= swap ? i_second_x : i_first_x;
    ay0_r <= swap ? i_second_y : i_first_y;
    bx0_r <= swap ? i_first_x : i_second_x;
    by0_r <= swap ? i_first_y : i_second_y;

    // Stage 1
    ax1_r    <= ax0_r;
    ay1_r    <= ay0_r;
    bx1_r    <= bx0_r;
    by1_r    <= by0_r;
    c1_1_r   <= c1_nxt;
    c2_1_r   <= c2_nxt;
    dx1_r    <= {bx0_r[W-1], bx0_r} - {ax0_r[W-1], ax0_r};
    dy1_r    <= {by0_r[W-1], by0_r} - {ay0_r[W-1], ay0_r};
    dxl1_r   <= {win_xmin[W-1], win_xmin} - {ax0_r[W-1], ax0_r};
    dxr1_r   <= {win_xmax[W-1], win_xmax} - {ax0_r[W-1], ax0_r};
    dyb1_r   <= {win_ymin[W-1], win_ymin} - {ay0_r[W-1], ay0_r};
    dyt1_r   <= {win_ymax[W-1], win_ymax} - {ay0_r[W-1], ay0_r};
    empty1_r <= (win_xmin > win_xmax) || (win_ymin > win_ymax);
    bxgt1_r  <= bx0_r > win_xmax;

    // Stage 2
    ax2_r      <= ax1_r;
    ay2_r      <= ay1_r;
    bx2_r      <= bx1_r;
    by2_r      <= by1_r;
    c1_2_r     <= c1_1_r;
    c2_2_r     <= c2_1_r;
    empty2_r   <= empty1_r;
    bxgt2_r    <= bxgt1_r;
    dypos2_r   <= !dy1_r[W] && (dy1_r != '0);
    dyneg2_r   <= dy1_r[W];
    p_dydxr_r  <= dy1_r * dxr1_r;
    p_dydxl_r  <= dy1_r * dxl1_r;
    p_dxdyt_r  <= dx1_r * dyt1_r;
    p_dxdyb_r  <= dx1_r * dyb1_r;
    p_dybdxr_r <= dyb1_r * dxr1_r;
    p_dxldyt_r <= dxl1_r * dyt1_r;
    p_dytdxr_r <= dyt1_r * dxr1_r;
    p_dxldyb_r <= dxl1_r * dyb1_r;

    // Stage 3
    ax3_r    <= ax2_r;
    ay3_r    <= ay2_r;
    bx3_r    <= bx2_r;
    by3_r    <= by2_r;
    c1_3_r   <= c1_2_r;
    c2_3_r   <= c2_2_r;
    empty3_r <= empty2_r;
    bxgt3_r  <= bxgt2_r;
    dypos3_r <= dypos2_r;
    dyneg3_r <= dyneg2_r;
    lt_rt_r  <= p_dydxr_r < p_dxdyt_r;
    gt_rt_r  <= p_dydxr_r > p_dxdyt_r;
    lt_rb_r  <= p_dydxr_r < p_dxdyb_r;
    gt_rb_r  <= p_dydxr_r > p_dxdyb_r;
    gt_lt_r  <= p_dydxl_r > p_dxdyt_r;
    lt_lb_r  <= p_dydxl_r < p_dxdyb_r;
    lt_c_r   <= p_dybdxr_r < p_dxldyt_r;
    gt_c_r   <= p_dytdxr_r > p_dxldyb_r;

    // Stage 4
    o_vis <= vis_nxt;
    o_k1  <= k1_nxt;
    o_k2  <= k2_nxt;
    o_ax  <= ax3_r;
    o_ay  <= ay3_r;
    o_bx  <= bx3_r;
    o_by  <= by3_r;
  end

  // Region decision. The first cut runs before the second one, and the
  // second one sees the endpoints that the first one left.
  always_comb begin
    vis_nxt = 1'b0;
    k1_nxt  = '{en: 1'b0, mv: lswc_pkg::MOVE_A, edge_sel: lswc_pkg::EDGE_XMIN};
    k2_nxt  = '{en: 1'b0, mv: lswc_pkg::MOVE_A, edge_sel: lswc_pkg::EDGE_XMIN};
    if (!empty3_r && ((c1_3_r & c2_3_r) == lswc_pkg::OC_INSIDE)) begin
      case (c1_3_r)
        lswc_pkg::OC_INSIDE: begin
          vis_nxt = 1'b1;
          if (c2_3_r != lswc_pkg::OC_INSIDE) begin
            if (!dyneg3_r) begin
              k1_nxt = lt_rt_r ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX)
                               : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMAX);
            end else begin
              k1_nxt = lt_rb_r ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMIN)
                               : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX);
            end
          end
        end
        lswc_pkg::OC_LEFT: begin
          vis_nxt = 1'b1;
          k2_nxt  = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_XMIN);
          if (c2_3_r != lswc_pkg::OC_INSIDE) begin
            if (!dyneg3_r) begin
              if (gt_lt_r) begin
                vis_nxt   = 1'b0;
                k2_nxt.en = 1'b0;
              end else begin
                k1_nxt = lt_rt_r ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX)
                                 : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMAX);
              end
            end else begin
              if (lt_lb_r) begin
                vis_nxt   = 1'b0;
                k2_nxt.en = 1'b0;
              end else begin
                k1_nxt = lt_rb_r ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMIN)
                                 : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX);
              end
            end
          end
        end
        lswc_pkg::OC_BELOW: begin
          if (c2_3_r == lswc_pkg::OC_INSIDE) begin
            vis_nxt = 1'b1;
            k2_nxt  = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMIN);
          end else if (dypos3_r && !lt_rb_r) begin
            vis_nxt = 1'b1;
            k1_nxt  = lt_rt_r ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX)
                              : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMAX);
            k2_nxt  = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMIN);
          end
        end
        lswc_pkg::OC_ABOVE: begin
          if (c2_3_r == lswc_pkg::OC_INSIDE) begin
            vis_nxt = 1'b1;
            k2_nxt  = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMAX);
          end else if (dyneg3_r && !gt_rt_r) begin
            vis_nxt = 1'b1;
            k1_nxt  = gt_rb_r ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX)
                              : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMIN);
            k2_nxt  = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMAX);
          end
        end
        lswc_pkg::OC_LEFT_BELOW: begin
          if (dypos3_r && !gt_lt_r && !lt_rb_r) begin
            vis_nxt = 1'b1;
            if (lt_c_r ? lt_lb_r : lt_rt_r) begin
              k1_nxt = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMIN);
              if (bxgt3_r) k2_nxt = mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX);
            end else if (!lt_c_r && lt_lb_r) begin
              k1_nxt = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMIN);
              if (c2_3_r != lswc_pkg::OC_INSIDE) begin
                k2_nxt = mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMAX);
              end
            end else begin
              k1_nxt = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_XMIN);
              if (c2_3_r != lswc_pkg::OC_INSIDE) begin
                k2_nxt = (lt_c_r && lt_rt_r) ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX)
                                             : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMAX);
              end
            end
          end
        end
        lswc_pkg::OC_LEFT_ABOVE: begin
          if (dyneg3_r && !gt_rt_r && !lt_lb_r) begin
            vis_nxt = 1'b1;
            if (gt_c_r ? gt_lt_r : gt_rb_r) begin
              k1_nxt = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMAX);
              if (bxgt3_r) k2_nxt = mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX);
            end else if (!gt_c_r && gt_lt_r) begin
              k1_nxt = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_YMAX);
              if (c2_3_r != lswc_pkg::OC_INSIDE) begin
                k2_nxt = mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMIN);
              end
            end else begin
              k1_nxt = mk(lswc_pkg::MOVE_A, lswc_pkg::EDGE_XMIN);
              if (c2_3_r != lswc_pkg::OC_INSIDE) begin
                k2_nxt = (gt_c_r && gt_rb_r) ? mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_XMAX)
                                             : mk(lswc_pkg::MOVE_B, lswc_pkg::EDGE_YMIN);
              end
            end
          end
        end
        default: begin
          vis_nxt = 1'b0;
        end
      endcase
    end
  end

endmodule

[src/lswc_cut.sv]
// One edge cut of the clipper: moves one endpoint onto a window edge.
// Pipelined: setup, multiply, overflow check, one quotient bit per stage, merge.
// Depends on lswc_pkg.
module lswc_cut #(
  parameter int W      = 16,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  i_valid,
  input  logic signed [W-1:0]   i_ax,
  input  logic signed [W-1:0]   i_ay,
  input  logic signed [W-1:0]   i_bx,
  input  logic signed [W-1:0]   i_by,
  input  lswc_pkg::cut_desc_t   i_desc,
  input  logic [SIDE_W-1:0]     i_side,
  input  logic signed [W-1:0]   win_xmin,
  input  logic signed [W-1:0]   win_xmax,
  input  logic signed [W-1:0]   win_ymin,
  input  logic signed [W-1:0]   win_ymax,
  output logic                  o_valid,
  output logic signed [W-1:0]   o_ax,
  output logic signed [W-1:0]   o_ay,
  output logic signed [W-1:0]   o_bx,
  output logic signed [W-1:0]   o_by,
  output logic [SIDE_W-1:0]     o_side
);

  localparam int K  = W + 1;      // quotient bits below the saturation point
  localparam int PW = 2 * W + 2;  // product width

  typedef struct packed {
    logic [W-1:0]      ax;
    logic [W-1:0]      ay;
    logic [W-1:0]      bx;
    logic [W-1:0]      by;
    logic              en;
    lswc_pkg::move_t   mv;
    logic              axis_y;
    logic [W-1:0]      e;
    logic              neg;
    logic              den0;
    logic [SIDE_W-1:0] side;
  } ctl_t;

  // Setup stage next values.
  logic              axis_y_nxt;
  logic [W-1:0]      e_nxt, ua, va, ub, vb;
  logic signed [W:0] den_nxt, num_nxt, dlt_nxt;
  ctl_t              ctl_nxt;

  logic              vd_r;
  ctl_t              ctl_d_r;
  logic [W:0]        dmag_d_r, nmag_d_r, den_d_r;

  logic              vm_r;
  ctl_t              ctl_m_r;
  logic [PW-1:0]     prod_m_r;
  logic [W:0]        den_m_r;

  // Divider pipeline; entry 0 is the overflow-check stage.
  logic              vld_r  [0:K];
  ctl_t              ctl_r  [0:K];
  logic [PW-1:0]     rem_r  [0:K];
  logic [K-1:0]      q_r    [0:K];
  logic              ovf_r  [0:K];
  logic [W:0]        dv_r   [0:K];

  always_comb begin
    axis_y_nxt = (i_desc.edge_sel == lswc_pkg::EDGE_YMIN) ||
                 (i_desc.edge_sel == lswc_pkg::EDGE_YMAX);
    case (i_desc.edge_sel)
      lswc_pkg::EDGE_XMIN: e_nxt = win_xmin;
      lswc_pkg::EDGE_XMAX: e_nxt = win_xmax;
      lswc_pkg::EDGE_YMIN: e_nxt = win_ymin;
      lswc_pkg::EDGE_YMAX: e_nxt = win_ymax;
      default:             e_nxt = win_xmin;
    endcase
    ua      = axis_y_nxt ? i_ay : i_ax;
    va      = axis_y_nxt ? i_ax : i_ay;
    ub      = axis_y_nxt ? i_by : i_bx;
    vb      = axis_y_nxt ? i_bx : i_by;
    den_nxt = {ub[W-1], ub} - {ua[W-1], ua};
    num_nxt = {vb[W-1], vb} - {va[W-1], va};
    dlt_nxt = {e_nxt[W-1], e_nxt} - {ua[W-1], ua};
    ctl_nxt.ax     = i_ax;
    ctl_nxt.ay     = i_ay;
    ctl_nxt.bx     = i_bx;
    ctl_nxt.by     = i_by;
    ctl_nxt.en     = i_desc.en;
    ctl_nxt.mv     = i_desc.mv;
    ctl_nxt.axis_y = axis_y_nxt;
    ctl_nxt.e      = e_nxt;
    ctl_nxt.neg    = dlt_nxt[W] ^ num_nxt[W] ^ den_nxt[W];
    ctl_nxt.den0   = den_nxt == '0;
    ctl_nxt.side   = i_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r     <= 1'b0;
      vm_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      vd_r     <= i_valid;
      vm_r     <= vd_r;
      vld_r[0] <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl_d_r  <= ctl_nxt;
    dmag_d_r <= dlt_nxt[W] ? -dlt_nxt : dlt_nxt;
    nmag_d_r <= num_nxt[W] ? -num_nxt : num_nxt;
    den_d_r  <= den_nxt[W] ? -den_nxt : den_nxt;

    ctl_m_r  <= ctl_d_r;
    prod_m_r <= dmag_d_r * nmag_d_r;
    den_m_r  <= den_d_r;

    // A quotient of 2**K or more saturates any coordinate anyway.
    ctl_r[0] <= ctl_m_r;
    rem_r[0] <= prod_m_r;
    q_r[0]   <= '0;
    ovf_r[0] <= prod_m_r >= {den_m_r, {K{1'b0}}};
    dv_r[0]  <= den_m_r;
  end

  for (genvar j = 0; j < K; j++) begin : g_div
    localparam int SH = K - 1 - j;
    logic [PW-1:0] trial;
    logic          take;

    assign trial = {{(W + 1){1'b0}}, dv_r[j]} << SH;
    assign take  = rem_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[j+1] <= ctl_r[j];
      rem_r[j+1] <= take ? rem_r[j] - trial : rem_r[j];
      q_r[j+1]   <= q_r[j] | (take ? ({{(K - 1){1'b0}}, 1'b1} << SH) : {K{1'b0}});
      ovf_r[j+1] <= ovf_r[j];
      dv_r[j+1]  <= dv_r[j];
    end
  end

  // Merge stage.
  ctl_t                c;
  logic [W-1:0]        va_f, vmv_f, lo_f, hi_f, vclamp, vsat, vnew, nx, ny;
  logic [K:0]          magq;
  logic signed [W+2:0] off, sum;

  localparam logic signed [W+2:0] SMAX = {4'b0000, {(W - 1){1'b1}}};
  localparam logic signed [W+2:0] SMIN = {4'b1111, {(W - 1){1'b0}}};

  always_comb begin
    c     = ctl_r[K];
    va_f  = c.axis_y ? c.ax : c.ay;
    vmv_f = (c.mv == lswc_pkg::MOVE_B) ? (c.axis_y ? c.bx : c.by)
                                       : (c.axis_y ? c.ax : c.ay);
    lo_f  = c.axis_y ? win_xmin : win_ymin;
    hi_f  = c.axis_y ? win_xmax : win_ymax;
    magq  = ovf_r[K] ? {1'b1, {K{1'b0}}} : {1'b0, q_r[K]};
    off   = c.neg ? -$signed({1'b0, magq}) : $signed({1'b0, magq});
    sum   = $signed({{3{va_f[W-1]}}, va_f}) + off;
    if (sum > SMAX) begin
      vsat = {1'b0, {(W - 1){1'b1}}};
    end else if (sum < SMIN) begin
      vsat = {1'b1, {(W - 1){1'b0}}};
    end else begin
      vsat = sum[W-1:0];
    end
    // A segment running along the edge keeps its own coordinate, held in the window.
    if ($signed(vmv_f) < $signed(lo_f)) begin
      vclamp = lo_f;
    end else if ($signed(vmv_f) > $signed(hi_f)) begin
      vclamp = hi_f;
    end else begin
      vclamp = vmv_f;
    end
    vnew = c.den0 ? vclamp : vsat;
    nx   = c.axis_y ? vnew : c.e;
    ny   = c.axis_y ? c.e : vnew;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= vld_r[K];
    end
  end

  always_ff @(posedge clk) begin
    o_side <= c.side;
    o_ax   <= (c.en && c.mv == lswc_pkg::MOVE_A) ? nx : c.ax;
    o_ay   <= (c.en && c.mv == lswc_pkg::MOVE_A) ? ny : c.ay;
    o_bx   <= (c.en && c.mv == lswc_pkg::MOVE_B) ? nx : c.bx;
    o_by   <= (c.en && c.mv == lswc_pkg::MOVE_B) ? ny : c.by;
  end

endmodule

[bench/lswc_checker.sv]
// Checker for the line segment window clipper: watches the segment, result and
// window register ports, predicts each clipped segment and compares.
// Depends on lswc_pkg.
`timescale 1ns / 100ps

module lswc_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic signed [COORD_BITS-1:0]   in_first_x,
  input  logic signed [COORD_BITS-1:0]   in_first_y,
  input  logic signed [COORD_BITS-1:0]   in_second_x,
  input  logic signed [COORD_BITS-1:0]   in_second_y,
  input  logic                           out_valid,
  input  logic                           out_visible,
  input  logic signed [COORD_BITS-1:0]   out_clip_left_x,
  input  logic signed [COORD_BITS-1:0]   out_clip_left_y,
  input  logic signed [COORD_BITS-1:0]   out_clip_right_x,
  input  logic signed [COORD_BITS-1:0]   out_clip_right_y,
  input  logic                           cfg_we,
  input  logic [lswc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             visible_seen
);

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct {
    logic                  vis;
    logic [COORD_BITS-1:0] lx;
    logic [COORD_BITS-1:0] ly;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
  } clipped_seg_t;

  clipped_seg_t clip_queue[$];
  logic signed [COORD_BITS-1:0] reg_xmin, reg_xmax, reg_ymin, reg_ymax;
  longint wx0, wx1, wy0, wy1;

  localparam longint CMAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Products of 17-bit differences fit easily in 64 bits, so compare exactly.
  function automatic bit slope_lt(longint p, longint q, longint r, longint s);
    return p * q < r * s;
  endfunction

  function automatic bit slope_gt(longint p, longint q, longint r, longint s);
    return p * q > r * s;
  endfunction

  function automatic point_t cut_x(point_t a, point_t b, point_t mv, longint e);
    point_t r;
    r.x = e;
    if (b.x == a.x) r.y = clampv(mv.y, wy0, wy1);
    else r.y = clampv(a.y + ((e - a.x) * (b.y - a.y)) / (b.x - a.x), CMIN, CMAX);
    return r;
  endfunction

  function automatic point_t cut_y(point_t a, point_t b, point_t mv, longint e);
    point_t r;
    r.y = e;
    if (b.y == a.y) r.x = clampv(mv.x, wx0, wx1);
    else r.x = clampv(a.x + ((e - a.y) * (b.x - a.x)) / (b.y - a.y), CMIN, CMAX);
    return r;
  endfunction

  function automatic int region_of(point_t p);
    int c;
    c = 0;
    if (p.x < wx0) c |= lswc_pkg::OC_LEFT;
    if (p.x > wx1) c |= lswc_pkg::OC_RIGHT;
    if (p.y < wy0) c |= lswc_pkg::OC_BELOW;
    if (p.y > wy1) c |= lswc_pkg::OC_ABOVE;
    return c;
  endfunction

  function automatic bit clip_segment(inout point_t a, inout point_t b);
    int c1, c2;
    longint dx, dy, dxl, dxr, dyb, dyt;
    c1 = region_of(a);
    c2 = region_of(b);
    dx = b.x - a.x;  dy = b.y - a.y;
    dxl = wx0 - a.x; dxr = wx1 - a.x;
    dyb = wy0 - a.y; dyt = wy1 - a.y;
    if (wx0 > wx1 || wy0 > wy1 || (c1 & c2) != 0) return 0;
    if (c1 == lswc_pkg::OC_INSIDE) begin
      if (c2 == lswc_pkg::OC_INSIDE) return 1;
      if (dy >= 0) begin
        if (slope_lt(dy, dxr, dx, dyt)) b = cut_x(a, b, b, wx1);
        else b = cut_y(a, b, b, wy1);
      end else begin
        if (slope_lt(dy, dxr, dx, dyb)) b = cut_y(a, b, b, wy0);
        else b = cut_x(a, b, b, wx1);
      end
      return 1;
    end
    if (c1 == lswc_pkg::OC_LEFT) begin
      if (c2 != lswc_pkg::OC_INSIDE) begin
        if (dy >= 0) begin
          if (slope_gt(dy, dxl, dx, dyt)) return 0;
          if (slope_lt(dy, dxr, dx, dyt)) b = cut_x(a, b, b, wx1);
          else b = cut_y(a, b, b, wy1);
        end else begin
          if (slope_lt(dy, dxl, dx, dyb)) return 0;
          if (slope_lt(dy, dxr, dx, dyb)) b = cut_y(a, b, b, wy0);
          else b = cut_x(a, b, b, wx1);
        end
      end
      a = cut_x(a, b, a, wx0);
      return 1;
    end
    if (c1 == lswc_pkg::OC_BELOW) begin
      if (c2 != lswc_pkg::OC_INSIDE) begin
        if (dy <= 0 || slope_lt(dy, dxr, dx, dyb)) return 0;
        if (slope_lt(dy, dxr, dx, dyt)) b = cut_x(a, b, b, wx1);
        else b = cut_y(a, b, b, wy1);
      end
      a = cut_y(a, b, a, wy0);
      return 1;
    end
    if (c1 == lswc_pkg::OC_ABOVE) begin
      if (c2 != lswc_pkg::OC_INSIDE) begin
        if (dy >= 0 || slope_gt(dy, dxr, dx, dyt)) return 0;
        if (slope_gt(dy, dxr, dx, dyb)) b = cut_x(a, b, b, wx1);
        else b = cut_y(a, b, b, wy0);
      end
      a = cut_y(a, b, a, wy1);
      return 1;
    end
    if (c1 == lswc_pkg::OC_LEFT_BELOW) begin
      if (dy <= 0 || slope_gt(dy, dxl, dx, dyt) || slope_lt(dy, dxr, dx, dyb)) return 0;
      if (slope_lt(dyb, dxr, dxl, dyt) ? slope_lt(dy, dxl, dx, dyb)
                                       : slope_lt(dy, dxr, dx, dyt)) begin
        a = cut_y(a, b, a, wy0);
        if (b.x > wx1) b = cut_x(a, b, b, wx1);
        return 1;
      end
      if (!slope_lt(dyb, dxr, dxl, dyt) && slope_lt(dy, dxl, dx, dyb)) begin
        a = cut_y(a, b, a, wy0);
        if (c2 != lswc_pkg::OC_INSIDE) b = cut_y(a, b, b, wy1);
        return 1;
      end
      a = cut_x(a, b, a, wx0);
      if (c2 == lswc_pkg::OC_INSIDE) return 1;
      if (slope_lt(dyb, dxr, dxl, dyt) && slope_lt(dy, dxr, dx, dyt)) b = cut_x(a, b, b, wx1);
      else b = cut_y(a, b, b, wy1);
      return 1;
    end
    if (c1 == lswc_pkg::OC_LEFT_ABOVE) begin
      if (dy >= 0 || slope_gt(dy, dxr, dx, dyt) || slope_lt(dy, dxl, dx, dyb)) return 0;
      if (slope_gt(dyt, dxr, dxl, dyb) ? slope_gt(dy, dxl, dx, dyt)
                                       : slope_gt(dy, dxr, dx, dyb)) begin
        a = cut_y(a, b, a, wy1);
        if (b.x > wx1) b = cut_x(a, b, b, wx1);
        return 1;
      end
      if (!slope_gt(dyt, dxr, dxl, dyb) && slope_gt(dy, dxl, dx, dyt)) begin
        a = cut_y(a, b, a, wy1);
        if (c2 != lswc_pkg::OC_INSIDE) b = cut_y(a, b, b, wy0);
        return 1;
      end
      a = cut_x(a, b, a, wx0);
      if (c2 == lswc_pkg::OC_INSIDE) return 1;
      if (slope_gt(dyt, dxr, dxl, dyb) && slope_gt(dy, dxr, dx, dyb)) b = cut_x(a, b, b, wx1);
      else b = cut_y(a, b, b, wy0);
      return 1;
    end
    return 0;
  endfunction

  function automatic clipped_seg_t predict_clip(longint fx, longint fy,
                                                longint sx, longint sy);
    point_t a, b, ca, cb, t;
    bit vis;
    clipped_seg_t r;
    a.x = fx; a.y = fy; b.x = sx; b.y = sy;
    if (a.x > b.x) begin
      t = a; a = b; b = t;
    end
    ca = a;
    cb = b;
    vis = clip_segment(ca, cb);
    if (!vis) begin
      ca = a; cb = b;
    end
    r.vis = vis;
    r.lx = ca.x[COORD_BITS-1:0];
    r.ly = ca.y[COORD_BITS-1:0];
    r.rx = cb.x[COORD_BITS-1:0];
    r.ry = cb.y[COORD_BITS-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [COORD_BITS-1:0] exp_v,
                               logic [COORD_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name,
               $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  assign pending = clip_queue.size();

  always @(posedge clk) begin
    clipped_seg_t e;
    if (!rst_n) begin
      reg_xmin <= '0;
      reg_xmax <= CMAX[COORD_BITS-1:0];
      reg_ymin <= '0;
      reg_ymax <= CMAX[COORD_BITS-1:0];
      clip_queue.delete();
      fail_count = 0;
      checked <= 0;
      visible_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lswc_pkg::REG_WIN_XMIN: reg_xmin <= cfg_data;
          lswc_pkg::REG_WIN_XMAX: reg_xmax <= cfg_data;
          lswc_pkg::REG_WIN_YMIN: reg_ymin <= cfg_data;
          lswc_pkg::REG_WIN_YMAX: reg_ymax <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        wx0 = reg_xmin; wx1 = reg_xmax; wy0 = reg_ymin; wy1 = reg_ymax;
        clip_queue.push_back(predict_clip(in_first_x, in_first_y, in_second_x, in_second_y));
      end
      if (out_valid) begin
        if (clip_queue.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual visible=%0b",
                   $time, out_visible);
          fail_count++;
        end else begin
          e = clip_queue.pop_front();
          if (e.vis !== out_visible) begin
            $display("%0t: mismatch on visible: expected %0b, actual %0b", $time,
                     e.vis, out_visible);
            fail_count++;
          end
          compare_field("clip_left_x", e.lx, out_clip_left_x);
          compare_field("clip_left_y", e.ly, out_clip_left_y);
          compare_field("clip_right_x", e.rx, out_clip_right_x);
          compare_field("clip_right_y", e.ry, out_clip_right_y);
          checked <= checked + 1;
          if (out_visible) visible_seen <= visible_seen + 1;
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
// Top of the clipper testbench: clock, reset, window setup, segment stimulus
// and verdict. Depends on lswc_pkg, lswc_checker and the clipper top level.
`timescale 1ns / 100ps

module testbench;

  localparam int CB = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  // An index past the last window register.
  localparam logic [lswc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd5;

  logic clk, rst_n, start, busy, cfg_we;
  logic signed [CB-1:0] in_first_x, in_first_y, in_second_x, in_second_y;
  logic out_valid, out_visible;
  logic signed [CB-1:0] out_clip_left_x, out_clip_left_y, out_clip_right_x, out_clip_right_y;
  logic [lswc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CB-1:0] cfg_data;
  int fail_count, pending, checked, visible_seen;
  int segs_sent, stall_cycles;
  bit idle_on;
  int win_lo_x, win_hi_x, win_lo_y, win_hi_y;

  line_segment_window_clipper_unit #(.COORD_BITS(CB)) i_dut (.*);

  lswc_checker #(.COORD_BITS(CB)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run if neither a segment nor a result word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  // Mostly coordinates around the current window, some anywhere, some extremes.
  function automatic int pick_coord(int lo, int hi);
    int span, sel;
    sel = $urandom_range(0, 15);
    span = (hi > lo ? hi - lo : lo - hi) + 64;
    if (sel < 2) return $signed(16'($urandom));
    if (sel == 2) return -32768;
    if (sel == 3) return 32767;
    if (sel == 4) return lo;
    if (sel == 5) return hi;
    return clamp_coord($urandom_range(0, 3 * span) + (lo < hi ? lo : hi) - span);
  endfunction

  task automatic send_seg(int fx, int fy, int sx, int sy);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_first_x = fx;  in_first_y = fy;
    in_second_x = sx; in_second_y = sy;
    do @(posedge clk); while (busy);
    segs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [lswc_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CB-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_window(int x0, int x1, int y0, int y1);
    drain_results();
    write_reg(lswc_pkg::REG_WIN_XMIN, x0);
    write_reg(lswc_pkg::REG_WIN_XMAX, x1);
    write_reg(lswc_pkg::REG_WIN_YMIN, y0);
    write_reg(lswc_pkg::REG_WIN_YMAX, y1);
    win_lo_x = x0; win_hi_x = x1; win_lo_y = y0; win_hi_y = y1;
  endtask

  task automatic random_segs(int count);
    int fx, fy, sx, sy;
    repeat (count) begin
      fx = pick_coord(win_lo_x, win_hi_x);
      fy = pick_coord(win_lo_y, win_hi_y);
      sx = pick_coord(win_lo_x, win_hi_x);
      sy = pick_coord(win_lo_y, win_hi_y);
      case ($urandom_range(0, 9))
        0: sx = fx;
        1: sy = fy;
        2: begin
          sx = fx; sy = fy;
        end
        default: ;
      endcase
      send_seg(fx, fy, sx, sy);
    end
  endtask

  initial begin
    int x0, y0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_first_x = '0; in_first_y = '0; in_second_x = '0; in_second_y = '0;
    segs_sent = 0;
    idle_on = 1'b1;
    win_lo_x = 0; win_hi_x = 32767; win_lo_y = 0; win_hi_y = 32767;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part against the reset window, then a small window.
    send_seg(100, 100, 200, 300);
    send_seg(-32768, -32768, 32767, 32767);
    send_seg(32767, 32767, -32768, -32768);
    send_seg(-100, -50, -10, -5);
    send_seg(-32768, 32767, 32767, -32768);
    send_seg(5, 5, 5, 5);
    set_window(-800, 800, -400, 400);
    send_seg(-1000, 0, 1000, 0);
    send_seg(0, -1000, 0, 1000);
    send_seg(-900, -500, 900, 500);
    send_seg(-900, 500, 900, -500);
    send_seg(-900, 0, 100, 900);
    send_seg(-900, 0, 100, -900);
    send_seg(0, -900, 900, 100);
    send_seg(0, 900, 900, -100);
    send_seg(-1000, -1000, 0, 0);
    send_seg(-1000, 1000, 0, 0);
    send_seg(-1000, -1000, 1000, 1000);
    send_seg(-1000, 1000, 1000, -1000);
    send_seg(-800, -400, 800, 400);
    send_seg(-900, -300, -900, 300);
    send_seg(-900, 400, 900, 400);
    send_seg(0, 0, 32767, 100);
    // An index past the last register must leave the window alone.
    drain_results();
    write_reg(REG_UNUSED, 1234);
    send_seg(-900, -300, 900, 300);
    // Empty and one-wide windows.
    set_window(100, -100, -50, 50);
    send_seg(-200, 0, 200, 0);
    set_window(0, 0, -500, 500);
    send_seg(-200, -100, 200, 100);

    random_segs(150);
    set_window(-32768, 32767, -32768, 32767);
    random_segs(150);
    set_window(-3200, 4800, -1600, 2400);
    random_segs(150);
    x0 = $signed(16'($urandom));
    y0 = $signed(16'($urandom));
    set_window(x0, clamp_coord(x0 + $urandom_range(0, 20000)),
               y0, clamp_coord(y0 + $urandom_range(0, 20000)));
    random_segs(150);
    set_window(-16, 16, -8, 8);
    random_segs(150);
    set_window(32000, 32767, -32768, -32000);
    random_segs(150);
    set_window(-2000, 2000, -2000, 2000);
    idle_on = 1'b0;
    random_segs(150);

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d segments over ten window settings; %0d results checked, %0d visible.",
             segs_sent, checked, visible_seen);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
